FILE: design/cascaded_biquad_lowpass_assert.svh
// Assertion macros for the cascaded biquad lowpass.
`ifndef CASCADED_BIQUAD_LOWPASS_ASSERT_SVH
`define CASCADED_BIQUAD_LOWPASS_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CBQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cbq_pkg.sv
package cbq_pkg;

  localparam int unsigned COEF_W       = 32;
  localparam int unsigned GAIN_W       = 28;
  localparam int unsigned COEF_SH      = 28;
  localparam int unsigned GAIN_SH_BASE = 24;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [COEF_W-1:0] COEF_B0_RST = 32'h1000_0000;  // 1.0 in Q3.28
  localparam logic [GAIN_W-1:0] GAIN_RST    = 28'h100_0000;   // 1.0 in Q4.24

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD_X = 4'd1,
    OP_STAGE  = 4'd2,
    OP_ABS    = 4'd3,
    OP_MUL_LO = 4'd4,
    OP_MUL_HI = 4'd5,
    OP_SUM    = 4'd6,
    OP_ACC    = 4'd7,
    OP_SAT_W  = 4'd8,
    OP_SAT_Y  = 4'd9,
    OP_GAIN   = 4'd10,
    OP_OUT    = 4'd11
  } dp_op_e;

  typedef enum logic [1:0] {
    SRC_Z1 = 2'd0,
    SRC_Z2 = 2'd1,
    SRC_W  = 2'd2,
    SRC_X  = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    COEF_B0   = 3'd0,
    COEF_B1   = 3'd1,
    COEF_B2   = 3'd2,
    COEF_A1   = 3'd3,
    COEF_A2   = 3'd4,
    COEF_GAIN = 3'd5
  } coef_e;

  typedef struct packed {
    dp_op_e op;
    src_e   src;
    coef_e  coef;
    logic   sub;   // subtract the product instead of adding it
  } dp_cmd_t;

endpackage

FILE: design/cbq_regs.sv
module cbq_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cbq_pkg::COEF_W-1:0]           cfg_wdata_i,
  output cbq_pkg::cfg_t                        cfg_o
);

  cbq_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cbq_pkg::REG_B0:   cfg_d.b0   = cfg_wdata_i;
        cbq_pkg::REG_B1:   cfg_d.b1   = cfg_wdata_i;
        cbq_pkg::REG_B2:   cfg_d.b2   = cfg_wdata_i;
        cbq_pkg::REG_A1:   cfg_d.a1   = cfg_wdata_i;
        cbq_pkg::REG_A2:   cfg_d.a2   = cfg_wdata_i;
        cbq_pkg::REG_GAIN: cfg_d.gain = cfg_wdata_i[cbq_pkg::GAIN_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0   <= cbq_pkg::COEF_B0_RST;
      cfg_q.b1   <= '0;
      cfg_q.b2   <= '0;
      cfg_q.a1   <= '0;
      cfg_q.a2   <= '0;
      cfg_q.gain <= cbq_pkg::GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/cbq_datapath.sv
module cbq_datapath #(
  parameter int unsigned STAGES      = 6,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned STATE_BITS  = 40,
  localparam int unsigned STG_W      = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cbq_pkg::dp_cmd_t       cmd_i,
  input  logic [STG_W-1:0]       stage_i,
  input  cbq_pkg::cfg_t          cfg_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned FRAC_BITS = (STATE_BITS - SAMPLE_BITS) / 2;
  localparam int unsigned HALF      = (STATE_BITS + 1) / 2;
  localparam int unsigned MAG_W     = 2 * HALF;
  localparam int unsigned PP_W      = HALF + cbq_pkg::COEF_W;
  localparam int unsigned PROD_W    = MAG_W + cbq_pkg::COEF_W;
  localparam int unsigned ACC_W     = STATE_BITS + 6;
  localparam int unsigned GAIN_SH   = cbq_pkg::GAIN_SH_BASE + FRAC_BITS;

  localparam logic [PROD_W-1:0] RND_COEF = PROD_W'(1) << (cbq_pkg::COEF_SH - 1);
  localparam logic [PROD_W-1:0] RND_GAIN = PROD_W'(1) << (GAIN_SH - 1);

  localparam logic [STATE_BITS-1:0]  ST_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic [STATE_BITS-1:0]  ST_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [STATE_BITS-1:0]       x_q, z1_q, z2_q, w_q;
  logic [STATE_BITS-1:0]       d1_q [STAGES];
  logic [STATE_BITS-1:0]       d2_q [STAGES];
  logic [ACC_W-1:0]            acc_q;
  logic [MAG_W-1:0]            opm_q;
  logic [cbq_pkg::COEF_W-1:0]  cm_q;
  logic                        neg_q;
  logic [PP_W-1:0]             pp_q;
  logic [PROD_W-1:0]           prod_q;
  logic [SAMPLE_BITS-1:0]      dout_q;

  logic [STATE_BITS-1:0]       op_val, op_abs, x_in, st_sat;
  logic [cbq_pkg::COEF_W-1:0]  coef_val, coef_abs;
  logic                        is_gain;
  logic [HALF-1:0]             mul_a;
  logic [PP_W-1:0]             pp_d;
  logic [ACC_W-1:0]            rmag, rterm, acc_sum;
  logic [ACC_W-STATE_BITS:0]   st_hi;
  logic [ACC_W-SAMPLE_BITS:0]  smp_hi;
  logic                        st_ovf, smp_ovf;
  logic [SAMPLE_BITS-1:0]      smp_sat;

  always_comb begin
    case (cmd_i.src)
      cbq_pkg::SRC_Z1: op_val = z1_q;
      cbq_pkg::SRC_Z2: op_val = z2_q;
      cbq_pkg::SRC_W:  op_val = w_q;
      default:         op_val = x_q;
    endcase
    case (cmd_i.coef)
      cbq_pkg::COEF_B0:   coef_val = cfg_i.b0;
      cbq_pkg::COEF_B1:   coef_val = cfg_i.b1;
      cbq_pkg::COEF_B2:   coef_val = cfg_i.b2;
      cbq_pkg::COEF_A1:   coef_val = cfg_i.a1;
      cbq_pkg::COEF_A2:   coef_val = cfg_i.a2;
      cbq_pkg::COEF_GAIN: coef_val = cbq_pkg::COEF_W'(cfg_i.gain);
      default:            coef_val = '0;
    endcase
  end

  assign is_gain  = (cmd_i.coef == cbq_pkg::COEF_GAIN);
  assign op_abs   = op_val[STATE_BITS-1] ? (~op_val + 1'b1) : op_val;
  assign coef_abs = coef_val[cbq_pkg::COEF_W-1] ? (~coef_val + 1'b1) : coef_val;
  assign x_in     = STATE_BITS'($signed(sample_i)) << FRAC_BITS;

  // one shared multiplier, low half then high half of the magnitude
  assign mul_a = (cmd_i.op == cbq_pkg::OP_MUL_HI) ? opm_q[MAG_W-1:HALF] : opm_q[HALF-1:0];
  assign pp_d  = PP_W'(mul_a) * PP_W'(cm_q);

  // rounding constant already added, so this truncation rounds half away from zero
  assign rmag    = is_gain ? ACC_W'(prod_q >> GAIN_SH) : ACC_W'(prod_q >> cbq_pkg::COEF_SH);
  assign rterm   = neg_q ? (~rmag + 1'b1) : rmag;
  assign acc_sum = acc_q + rterm;

  assign st_hi   = acc_q[ACC_W-1:STATE_BITS-1];
  assign st_ovf  = !((&st_hi) || (~|st_hi));
  assign st_sat  = st_ovf ? (acc_q[ACC_W-1] ? ST_MIN : ST_MAX) : acc_q[STATE_BITS-1:0];
  assign smp_hi  = acc_q[ACC_W-1:SAMPLE_BITS-1];
  assign smp_ovf = !((&smp_hi) || (~|smp_hi));
  assign smp_sat = smp_ovf ? (acc_q[ACC_W-1] ? SMP_MIN : SMP_MAX) : acc_q[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cbq_pkg::OP_LOAD_X: x_q <= x_in;
      cbq_pkg::OP_STAGE: begin
        z1_q  <= d1_q[stage_i];
        z2_q  <= d2_q[stage_i];
        acc_q <= ACC_W'($signed(x_q));
      end
      cbq_pkg::OP_ABS: begin
        opm_q <= MAG_W'(op_abs);
        cm_q  <= coef_abs;
        neg_q <= op_val[STATE_BITS-1] ^ coef_val[cbq_pkg::COEF_W-1] ^ cmd_i.sub;
      end
      cbq_pkg::OP_MUL_LO: pp_q <= pp_d;
      cbq_pkg::OP_MUL_HI: begin
        pp_q   <= pp_d;
        prod_q <= PROD_W'(pp_q) + (is_gain ? RND_GAIN : RND_COEF);
      end
      cbq_pkg::OP_SUM: prod_q <= prod_q + (PROD_W'(pp_q) << HALF);
      cbq_pkg::OP_ACC: acc_q <= acc_sum;
      cbq_pkg::OP_SAT_W: begin
        w_q   <= st_sat;
        acc_q <= '0;
      end
      cbq_pkg::OP_SAT_Y: x_q <= st_sat;
      cbq_pkg::OP_GAIN:  acc_q <= '0;
      cbq_pkg::OP_OUT:   dout_q <= smp_sat;
      default: ;
    endcase
  end

  // section delay words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (cmd_i.op == cbq_pkg::OP_SAT_Y) begin
      d1_q[stage_i] <= w_q;
      d2_q[stage_i] <= z1_q;
    end
  end

  assign sample_o = dout_q;

endmodule

FILE: design/cbq_ctrl.sv
module cbq_ctrl #(
  parameter int unsigned STAGES = 6,
  localparam int unsigned STG_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output cbq_pkg::dp_cmd_t  cmd_o,
  output logic [STG_W-1:0]  stage_o
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_STAGE  = 11'b000_0000_0010,
    ST_ABS    = 11'b000_0000_0100,
    ST_MUL_LO = 11'b000_0000_1000,
    ST_MUL_HI = 11'b000_0001_0000,
    ST_SUM    = 11'b000_0010_0000,
    ST_ACC    = 11'b000_0100_0000,
    ST_SAT_W  = 11'b000_1000_0000,
    ST_SAT_Y  = 11'b001_0000_0000,
    ST_GAIN   = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    TERM_A1   = 3'd0,
    TERM_A2   = 3'd1,
    TERM_B0   = 3'd2,
    TERM_B1   = 3'd3,
    TERM_B2   = 3'd4,
    TERM_GAIN = 3'd5
  } term_e;

  state_e            state_q, state_d;
  term_e             term_q, term_d;
  logic [STG_W-1:0]  stage_q, stage_d;
  logic              out_valid_q, out_valid_d;
  logic              last_stage;
  cbq_pkg::dp_op_e   dp_op;

  assign last_stage = (stage_q == STG_W'(STAGES - 1));

  // operand and coefficient for the current product
  always_comb begin
    cmd_o.op = dp_op;
    case (term_q)
      TERM_A1: begin
        cmd_o.src = cbq_pkg::SRC_Z1; cmd_o.coef = cbq_pkg::COEF_A1; cmd_o.sub = 1'b1;
      end
      TERM_A2: begin
        cmd_o.src = cbq_pkg::SRC_Z2; cmd_o.coef = cbq_pkg::COEF_A2; cmd_o.sub = 1'b1;
      end
      TERM_B0: begin
        cmd_o.src = cbq_pkg::SRC_W;  cmd_o.coef = cbq_pkg::COEF_B0; cmd_o.sub = 1'b0;
      end
      TERM_B1: begin
        cmd_o.src = cbq_pkg::SRC_Z1; cmd_o.coef = cbq_pkg::COEF_B1; cmd_o.sub = 1'b0;
      end
      TERM_B2: begin
        cmd_o.src = cbq_pkg::SRC_Z2; cmd_o.coef = cbq_pkg::COEF_B2; cmd_o.sub = 1'b0;
      end
      default: begin
        cmd_o.src = cbq_pkg::SRC_X;  cmd_o.coef = cbq_pkg::COEF_GAIN; cmd_o.sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    stage_d     = stage_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dp_op       = cbq_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_op   = cbq_pkg::OP_LOAD_X;
          stage_d = '0;
          state_d = ST_STAGE;
        end
      end
      ST_STAGE: begin
        dp_op   = cbq_pkg::OP_STAGE;
        term_d  = TERM_A1;
        state_d = ST_ABS;
      end
      ST_ABS: begin
        dp_op   = cbq_pkg::OP_ABS;
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        dp_op   = cbq_pkg::OP_MUL_LO;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        dp_op   = cbq_pkg::OP_MUL_HI;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        dp_op   = cbq_pkg::OP_SUM;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        dp_op = cbq_pkg::OP_ACC;
        case (term_q)
          TERM_A1: begin
            term_d  = TERM_A2;
            state_d = ST_ABS;
          end
          TERM_A2: state_d = ST_SAT_W;
          TERM_B0: begin
            term_d  = TERM_B1;
            state_d = ST_ABS;
          end
          TERM_B1: begin
            term_d  = TERM_B2;
            state_d = ST_ABS;
          end
          TERM_B2: state_d = ST_SAT_Y;
          default: state_d = ST_OUT;
        endcase
      end
      ST_SAT_W: begin
        dp_op   = cbq_pkg::OP_SAT_W;
        term_d  = TERM_B0;
        state_d = ST_ABS;
      end
      ST_SAT_Y: begin
        dp_op = cbq_pkg::OP_SAT_Y;
        if (last_stage) begin
          state_d = ST_GAIN;
        end else begin
          stage_d = stage_q + 1'b1;
          state_d = ST_STAGE;
        end
      end
      ST_GAIN: begin
        dp_op   = cbq_pkg::OP_GAIN;
        term_d  = TERM_GAIN;
        state_d = ST_ABS;
      end
      ST_OUT: begin
        // hold until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          dp_op       = cbq_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_A1;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign stage_o     = stage_q;

endmodule

FILE: design/cascaded_biquad_lowpass.sv
// Channel      Signals                         Payload
// s_axis       s_axis_tvalid/tready/tdata      sample_in, one request per sample
// m_axis       m_axis_tvalid/tready/tdata      sample_out, one per request
// config       cfg_we_i/cfg_idx_i/cfg_wdata_i  b0 b1 b2 a1 a2 gain, write only
//
// Schedule: one shared multiplier, five products per section, then gain;
//   each product runs abs, low half, high half, sum and accumulate.
// Reset: rst_ni zeroes the delay words; b0 = 1.0, gain = 1.0, others 0.
// Stalls: s_axis_tready is high only while idle. A finished sample waits in
//   the output register while the next request runs; if still unclaimed
//   when that one finishes, the sequencer holds.

`include "cascaded_biquad_lowpass_assert.svh"

module cascaded_biquad_lowpass #(
  parameter int unsigned STAGES      = 6,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned STATE_BITS  = 40,
  localparam int unsigned DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [DATA_W-1:0]                 s_axis_tdata,   // sample_in, zero pad
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [DATA_W-1:0]                 m_axis_tdata,   // sample_out, zero pad
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cbq_pkg::COEF_W-1:0]        cfg_wdata_i
);

  localparam int unsigned STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  cbq_pkg::cfg_t          cfg;
  cbq_pkg::dp_cmd_t       dp_cmd;
  logic [STG_W-1:0]       stage_idx;
  logic [SAMPLE_BITS-1:0] sample_out;

  cbq_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer: walks sections and products, owns the handshakes
  cbq_ctrl #(
    .STAGES (STAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (dp_cmd),
    .stage_o     (stage_idx)
  );

  // arithmetic, delay words and output register
  cbq_datapath #(
    .STAGES      (STAGES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .stage_i  (stage_idx),
    .cfg_i    (cfg),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .sample_o (sample_out)
  );

  assign m_axis_tdata = DATA_W'(sample_out);

  // one request in flight at a time
  `CBQ_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while a sample is in flight")
  // output register is only loaded when it is free or draining
  `CBQ_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, dp_cmd.op == cbq_pkg::OP_OUT, !m_axis_tvalid || m_axis_tready, "pending result overwritten")
  // a new result only appears after the sequencer's output step
  `CBQ_ASSERT_SAME(a_out_from_seq, clk_i, rst_ni, $rose(m_axis_tvalid), $past(dp_cmd.op == cbq_pkg::OP_OUT), "result raised without an output step")

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Build matches the block defaults: six sections, 24-bit samples, 40-bit state.
  localparam int STAGES   = 6;
  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 40;
  localparam int FRAC     = (STATE_W - SAMPLE_W) / 2;  // internal bits below sample LSB
  localparam int DATA_W   = ((SAMPLE_W + 7) / 8) * 8;

  localparam int CFG_IDX_W    = cbq_pkg::CFG_IDX_W;
  localparam int COEF_W       = cbq_pkg::COEF_W;
  localparam int GAIN_W       = cbq_pkg::GAIN_W;
  localparam int COEF_SH      = cbq_pkg::COEF_SH;
  localparam int GAIN_SH_BASE = cbq_pkg::GAIN_SH_BASE;

  // Index codes the block does not decode; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;

  // Settle for longer than one sample takes through the block.
  localparam int SETTLE     = 200;
  localparam int LONG_HOLD  = 1200;   // receiver back-pressure stretch
  localparam int WATCHDOG   = 10000;  // cycles with no handshake on either side
  localparam int RAND_ITEMS = 170;    // per random phase
  localparam int MAX_SHOWN  = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;   // [23:0] sample_in
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;         // [23:0] sample_out

  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [COEF_W-1:0]    cfg_wdata_i = '0;

  cascaded_biquad_lowpass #(
    .STAGES     (STAGES),
    .SAMPLE_BITS(SAMPLE_W),
    .STATE_BITS (STATE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Filter mirror: coefficient set and per-section delay words
  // ---------------------------------------------------------------------
  longint cf_b0, cf_b1, cf_b2, cf_a1, cf_a2, cf_gain;
  longint sect_z1 [STAGES];
  longint sect_z2 [STAGES];

  // Samples waiting to be offered, and filtered samples owed by the block.
  logic [SAMPLE_W-1:0] sample_q [$];
  logic [SAMPLE_W-1:0] filtered_q [$];
  int queued_cnt = 0;     // samples handed to the driver
  int taken_cnt  = 0;     // samples the block accepted
  int fail_cnt   = 0;

  // Flow control knobs, set per phase by the sequence below.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;  // bumped by the sequence to ask for a long hold
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  logic [SAMPLE_W-1:0] want;

  function automatic longint clamp(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Exact product, rounded to nearest with ties away from zero, scaled down by sh.
  function automatic longint mul_rnd(input longint a, input longint c, input int sh);
    logic [95:0] ma, mc, prod;
    bit neg;
    neg  = (a < 0) != (c < 0);
    ma   = 96'((a < 0) ? -a : a);
    mc   = 96'((c < 0) ? -c : c);
    prod = ma * mc;
    prod = (prod + (96'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Direct form II per section: w = x - a1*z1 - a2*z2, y = b0*w + b1*z1 + b2*z2.
  function automatic logic [SAMPLE_W-1:0] run_cascade(input logic [SAMPLE_W-1:0] din);
    longint x, w, y, z1, z2;
    int k;
    x = longint'(signed'(din)) * (longint'(1) <<< FRAC);
    for (k = 0; k < STAGES; k++) begin
      z1 = sect_z1[k];
      z2 = sect_z2[k];
      w = clamp(x - mul_rnd(z1, cf_a1, COEF_SH) - mul_rnd(z2, cf_a2, COEF_SH), STATE_W);
      y = mul_rnd(w, cf_b0, COEF_SH) + mul_rnd(z1, cf_b1, COEF_SH)
        + mul_rnd(z2, cf_b2, COEF_SH);
      x = clamp(y, STATE_W);
      sect_z2[k] = z1;
      sect_z1[k] = w;
    end
    y = clamp(mul_rnd(x, cf_gain, GAIN_SH_BASE + FRAC), SAMPLE_W);
    return y[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued samples, predicts on every accepted request
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        filtered_q.push_back(run_cascade(s_axis_tdata[SAMPLE_W-1:0]));
        taken_cnt++;
      end
      // tvalid stays up with the same data until the request is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= DATA_W'(sample_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, long hold on request, in-order compare
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display("%0t: sample_out %h with no sample pending", $realtime,
                     m_axis_tdata[SAMPLE_W-1:0]);
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata[SAMPLE_W-1:0] !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_SHOWN)
              $display("%0t: sample_out expected %h actual %h", $realtime, want,
                       m_axis_tdata[SAMPLE_W-1:0]);
          end
        end
      end
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a long run with no handshake at all means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------
  task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
    sample_q.push_back(s);
    queued_cnt++;
  endtask

  // Mostly full-range noise, with quiet passages and full-scale hits mixed in.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1: return SAMPLE_W'(int'($urandom_range(2000)) - 1000);
      2: begin
        case ($urandom_range(3))
          0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
          1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
          2: return {1'b0, {(SAMPLE_W-2){1'b1}}, 1'b0};
          default: return {1'b1, {(SAMPLE_W-2){1'b0}}, 1'b1};
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Coefficient within roughly +-1.0 in Q3.28.
  function automatic logic [COEF_W-1:0] mild_coef();
    return COEF_W'(int'($urandom_range(536870912)) - 268435456);
  endfunction

  // One register write per cycle; the mirror follows immediately since the
  // block is idle whenever this runs.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      cbq_pkg::REG_B0:   cf_b0   = longint'(signed'(data));
      cbq_pkg::REG_B1:   cf_b1   = longint'(signed'(data));
      cbq_pkg::REG_B2:   cf_b2   = longint'(signed'(data));
      cbq_pkg::REG_A1:   cf_a1   = longint'(signed'(data));
      cbq_pkg::REG_A2:   cf_a2   = longint'(signed'(data));
      cbq_pkg::REG_GAIN: cf_gain = longint'(data[GAIN_W-1:0]);  // upper bits dropped
      default: ;
    endcase
  endtask

  // Full coefficient load, then junk to the undecoded indexes.
  task automatic load_filter(input logic [COEF_W-1:0] b0, b1, b2, a1, a2, gain);
    write_reg(cbq_pkg::REG_B0, b0);
    write_reg(cbq_pkg::REG_B1, b1);
    write_reg(cbq_pkg::REG_B2, b2);
    write_reg(cbq_pkg::REG_A1, a1);
    write_reg(cbq_pkg::REG_A2, a2);
    write_reg(cbq_pkg::REG_GAIN, gain);
    write_reg(IDX_SPARE_6, $urandom);
    write_reg(IDX_SPARE_7, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued sample was taken and every result came back.
  task automatic drain();
    while (taken_cnt != queued_cnt || filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) queue_sample(pick_sample());
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    cf_b0   = longint'(signed'(cbq_pkg::COEF_B0_RST));
    cf_b1   = 0;
    cf_b2   = 0;
    cf_a1   = 0;
    cf_a2   = 0;
    cf_gain = longint'(cbq_pkg::GAIN_RST);
    for (int k = 0; k < STAGES; k++) begin
      sect_z1[k] = 0;
      sect_z2[k] = 0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset coefficients pass samples straight through: field extremes and
    // alternating bit patterns.
    queue_sample(24'h000000);
    queue_sample(24'h000001);
    queue_sample(24'hFFFFFF);
    queue_sample(24'h7FFFFF);
    queue_sample(24'h800000);
    queue_sample(24'h555555);
    queue_sample(24'hAAAAAA);
    queue_sample(24'h000100);
    queue_sample(24'h7FFFFE);
    queue_sample(24'h800001);
    drain();

    // Largest b0 and gain (written with the excess bits set): full-scale
    // input blows past the internal range and the output range.
    load_filter(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    queue_sample(24'h7FFFFF);
    queue_sample(24'h800000);
    queue_sample(24'h000001);
    queue_sample(24'hFFFFFF);
    queue_sample(24'h000000);
    queue_sample(24'h001000);
    queue_sample(24'hFFF000);
    queue_sample(24'h7FFFFF);
    drain();

    // Plain second-order lowpass near fs/8, unity gain, no idling.
    load_filter(32'd26207600, 32'd52415200, 32'd26207600,
                -32'sd253084960, 32'd89478485, 32'd16777216);
    random_phase(RAND_ITEMS, 0, 0);

    // Very narrow resonant lowpass at gain 2: delays grow until they clip.
    load_filter(32'd13422, 32'd26844, 32'd13422,
                -32'sd534186557, 32'd265777947, 32'd33554432);
    random_phase(RAND_ITEMS, 65, 0);

    // Arbitrary bit patterns everywhere; the receiver also goes dark for a
    // long stretch while the sender keeps pushing, so the block backs up.
    load_filter($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    hold_asked++;
    random_phase(RAND_ITEMS, 0, 65);

    // Coefficient extremes, first with zero gain, then with the largest gain.
    load_filter(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    random_phase(60, 15, 15);
    write_reg(cbq_pkg::REG_GAIN, 32'hFFFF_FFFF);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    random_phase(110, 15, 15);

    // Mild random coefficients and gain; delays carry over from before.
    load_filter(mild_coef(), mild_coef(), mild_coef(), mild_coef(), mild_coef(),
                COEF_W'($urandom_range(33554432)));
    random_phase(RAND_ITEMS, 65, 65);

    // Back to the reset values, mixed flow control.
    load_filter(cbq_pkg::COEF_B0_RST, 32'h0, 32'h0, 32'h0, 32'h0,
                COEF_W'(cbq_pkg::GAIN_RST));
    random_phase(RAND_ITEMS, 15, 15);

    if (fail_cnt == 0 && filtered_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/cbq_pkg.sv
design/cbq_regs.sv
design/cbq_datapath.sv
design/cbq_ctrl.sv
design/cascaded_biquad_lowpass.sv
tb/testbench.sv
